// File: hdl/assert_macros.svh
// Assertion macros shared by the selective-repeat receiver window modules.
// Depends on nothing; included by each module file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SRRW_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("selective repeat window assertion failed");

// Antecedent implies consequent in the same cycle.
`define SRRW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("selective repeat window assertion failed");

// Antecedent implies consequent in the next cycle.
`define SRRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("selective repeat window assertion failed");

`endif

// File: hdl/srrw_pkg.sv
// Types, constants and helper functions of the selective-repeat receiver window.
// Depends on nothing; used by the interfaces and every module.
package srrw_pkg;

    localparam int SEQ_W       = 16;
    localparam int PLEN_W      = 10;
    localparam int WINDOW_MAX  = 32;
    localparam int WIN_CFG_W   = 6;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int ONES_W      = $clog2(WINDOW_MAX + 1);
    localparam int SEL_W       = 32;

    localparam logic [PLEN_W-1:0] CHUNK_BYTES = PLEN_W'(1000);
    localparam logic              OP_SEGMENT  = 1'b0;
    localparam logic              OP_TIMEOUT  = 1'b1;

    typedef logic [SEQ_W-1:0]      t_seq;
    typedef logic [WINDOW_MAX-1:0] t_map;

    typedef enum logic [1:0] {
        ST_RECEIVING = 2'd0,
        ST_LINGER    = 2'd1,
        ST_FINISHED  = 2'd2,
        ST_FAILED    = 2'd3
    } t_status;

    typedef struct packed {
        logic timeout;
        t_seq seq;
        logic short_seg;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_port;

    typedef struct packed {
        logic             ack_valid;
        t_seq             ack_base;
        logic [SEL_W-1:0] sack_bits;
        logic             store_payload;
        t_status          status;
    } t_result;

    function automatic logic [ONES_W-1:0] trailing_ones(input t_map v);
        logic [ONES_W-1:0] cnt;
        cnt = ONES_W'(WINDOW_MAX);
        for (int i = WINDOW_MAX - 1; i >= 0; i--) begin
            if (!v[i]) begin
                cnt = ONES_W'(i);
            end
        end
        return cnt;
    endfunction

endpackage

// File: hdl/srrw_ifs.sv
// Valid/ready channel interfaces for segment words in and acknowledgement words out.
// Depends on srrw_pkg.
interface srrw_seg_if import srrw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SEQ_W-1:0]  seq_num;
    logic [PLEN_W-1:0] payload_len;

    modport source (output valid, operation, seq_num, payload_len, input ready);
    modport sink (input valid, operation, seq_num, payload_len, output ready);
endinterface

interface srrw_ack_if import srrw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ack_valid;
    logic [SEQ_W-1:0] ack_base;
    logic [SEL_W-1:0] sack_bits;
    logic             store_payload;
    logic [1:0]       status;

    modport source (output valid, ack_valid, ack_base, sack_bits, store_payload, status,
                    input ready);
    modport sink (input valid, ack_valid, ack_base, sack_bits, store_payload, status,
                  output ready);
endinterface

// File: hdl/selective_repeat_receiver_window_top.sv
// Sustains one segment or timeout word per clock cycle while the ack sink reads. An accepted
// word's result is registered once it heads the queue and the output register is empty or being
// read. The rate rests on the combinational back-end window update, which sets the received
// bit, finds the first missing sequence number and slides the bitmap in one step. The queue
// between front and back holds QUEUE_DEPTH words and lets each side stall independently. No
// clearing pass follows reset. Write window_size only while no word is in flight.
// Top level of the selective-repeat receiver window; depends on srrw_pkg, srrw_ifs,
// srrw_front and srrw_back.
module selective_repeat_receiver_window_top
    import srrw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WIN_CFG_W-1:0] i_cfg_wdata,
    srrw_seg_if.sink             i_seg,
    srrw_ack_if.source           o_ack
);

    t_cmd_port head;
    logic      pop;

    srrw_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_pop   (pop),
        .o_head  (head)
    );

    srrw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_pop       (pop),
        .o_ack       (o_ack)
    );

endmodule

// File: hdl/srrw_front.sv
// Front end: accepts segment words, classifies them and queues the commands.
// Depends on srrw_pkg, srrw_ifs and assert_macros.svh.
`include "assert_macros.svh"

module srrw_front
    import srrw_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srrw_seg_if.sink    i_seg,
    input  logic        i_pop,
    output t_cmd_port   o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;
    logic              push;
    t_cmd              cmd_in;

    assign i_seg.ready = (r_count < CNT_W'(DEPTH));
    assign push        = i_seg.valid && i_seg.ready;

    always_comb begin
        cmd_in.timeout   = (i_seg.operation == OP_TIMEOUT);
        cmd_in.seq       = i_seg.seq_num;
        cmd_in.short_seg = (i_seg.payload_len < CHUNK_BYTES);
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    `SRRW_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `SRRW_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `SRRW_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, i_pop && !push,
                      r_count == $past(r_count) - CNT_W'(1))

endmodule

// File: hdl/srrw_back.sv
// Back end: applies queued commands to the receive window and registers the result word.
// Depends on srrw_pkg, srrw_ifs and assert_macros.svh.
`include "assert_macros.svh"

module srrw_back
    import srrw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WIN_CFG_W-1:0] i_cfg_wdata,
    input  t_cmd_port            i_head,
    output logic                 o_pop,
    srrw_ack_if.source           o_ack
);

    logic [WIN_CFG_W-1:0] r_win;
    t_seq                 r_base;
    t_map                 r_bitmap;
    t_seq                 r_final_seq;
    logic                 r_final_known;
    t_status              r_status;
    logic                 r_out_valid;
    t_result              r_res;

    logic [WIN_CFG_W-1:0] n_win;
    t_seq                 n_base;
    t_map                 n_bitmap;
    t_seq                 n_final_seq;
    logic                 n_final_known;
    t_status              n_status;
    logic                 n_out_valid;
    t_result              n_res;

    logic                 step;
    logic                 done;
    logic                 seg_live;
    t_seq                 off;
    logic                 in_win;
    logic                 is_new;
    t_map                 set_map;
    logic [ONES_W-1:0]    ones;
    logic                 complete;

    assign step  = i_head.valid && (!r_out_valid || o_ack.ready);
    assign o_pop = step;
    assign done  = (r_status == ST_FINISHED) || (r_status == ST_FAILED);

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_win = WIN_CFG_W'(1);
        end else if (i_cfg_wdata > WIN_CFG_W'(WINDOW_MAX)) begin
            n_win = WIN_CFG_W'(WINDOW_MAX);
        end else begin
            n_win = i_cfg_wdata;
        end
    end

    always_comb begin
        seg_live = !done && !i_head.cmd.timeout;
        off      = i_head.cmd.seq - r_base;
        in_win   = (off < SEQ_W'(r_win));
        is_new   = seg_live && in_win && !r_bitmap[off[IDX_W-1:0]];
        set_map  = r_bitmap | (is_new ? (t_map'(1) << off[IDX_W-1:0]) : '0);
        ones     = trailing_ones(set_map);
        if (seg_live && in_win) begin
            n_bitmap = set_map >> ones;
            n_base   = r_base + SEQ_W'(ones);
        end else begin
            n_bitmap = r_bitmap;
            n_base   = r_base;
        end
        if (is_new && i_head.cmd.short_seg) begin
            n_final_seq   = i_head.cmd.seq;
            n_final_known = 1'b1;
        end else begin
            n_final_seq   = r_final_seq;
            n_final_known = r_final_known;
        end
        complete = n_final_known && ((n_final_seq - n_base) >= SEQ_W'(WINDOW_MAX));
    end

    always_comb begin
        n_status = r_status;
        unique case (r_status)
            ST_FINISHED, ST_FAILED: begin
                n_status = r_status;
            end
            ST_RECEIVING, ST_LINGER: begin
                if (i_head.cmd.timeout) begin
                    n_status = (r_status == ST_LINGER) ? ST_FINISHED : ST_FAILED;
                end else begin
                    n_status = complete ? ST_LINGER : ST_RECEIVING;
                end
            end
        endcase
    end

    always_comb begin
        n_res.ack_valid     = seg_live;
        n_res.ack_base      = n_base;
        n_res.sack_bits     = SEL_W'({1'b0, n_bitmap[WINDOW_MAX-1:1]});
        n_res.store_payload = is_new;
        n_res.status        = n_status;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (o_ack.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win         <= WIN_CFG_W'(WINDOW_MAX);
            r_base        <= '0;
            r_bitmap      <= '0;
            r_final_seq   <= '0;
            r_final_known <= 1'b0;
            r_status      <= ST_RECEIVING;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= n_win;
            end
            if (step) begin
                r_base        <= n_base;
                r_bitmap      <= n_bitmap;
                r_final_seq   <= n_final_seq;
                r_final_known <= n_final_known;
                r_status      <= n_status;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= n_res;
        end
    end

    assign o_ack.valid         = r_out_valid;
    assign o_ack.ack_valid     = r_res.ack_valid;
    assign o_ack.ack_base      = r_res.ack_base;
    assign o_ack.sack_bits     = r_res.sack_bits;
    assign o_ack.store_payload = r_res.store_payload;
    assign o_ack.status        = r_res.status;

    `SRRW_ASSERT_ALWAYS(a_base_bit_clear, i_clk, i_rst_n, !r_bitmap[0])
    `SRRW_ASSERT_NEXT(a_finished_holds, i_clk, i_rst_n, r_status == ST_FINISHED,
                      r_status == ST_FINISHED)
    `SRRW_ASSERT_NEXT(a_failed_holds, i_clk, i_rst_n, r_status == ST_FAILED,
                      r_status == ST_FAILED)
    `SRRW_ASSERT_IMPL(a_store_needs_ack, i_clk, i_rst_n, r_out_valid && r_res.store_payload,
                      r_res.ack_valid)

endmodule

// File: verif/selective_repeat_receiver_window_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for selective_repeat_receiver_window_top: drives segment and timeout
// words, predicts every acknowledgement word from its own window model and checks them in order.
// Depends on srrw_pkg, srrw_ifs and the top level RTL.
module selective_repeat_receiver_window_top_tb;
    import srrw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic              op;
        t_seq              seq;
        logic [PLEN_W-1:0] plen;
    } t_seg_word;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [WIN_CFG_W-1:0] cfg_wdata = '0;

    srrw_seg_if seg_if ();
    srrw_ack_if ack_if ();

    selective_repeat_receiver_window_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_seg      (seg_if),
        .o_ack      (ack_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    t_seg_word   seg_pending[$];
    t_result     ack_expected[$];
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned ack_errors = 0;
    int unsigned cycle_count = 0;
    int unsigned src_wait = 0;
    int unsigned snk_wait = 0;
    int unsigned hold_left = 0;
    logic        seg_acc = 1'b0;
    logic        ack_fire = 1'b0;
    logic        src_burst = 1'b0;
    logic        snk_burst = 1'b0;
    logic        ack_hold_req = 1'b0;
    logic        hold_done = 1'b0;

    logic [WIN_CFG_W-1:0] rx_window_cfg = WIN_CFG_W'(WINDOW_MAX);
    t_seq                 rx_base = '0;
    t_map                 rx_held = '0;
    t_seq                 rx_last_seq = '0;
    logic                 rx_last_known = 1'b0;
    t_status              rx_state = ST_RECEIVING;

    function automatic int unsigned window_span(input logic [WIN_CFG_W-1:0] cfg);
        int unsigned span;
        span = 32'(cfg);
        if (span == 0) return 1;
        if (span > WINDOW_MAX) return WINDOW_MAX;
        return span;
    endfunction

    function automatic int unsigned idle_draw(input logic burst);
        return burst ? 0 : $urandom_range(14, 0);
    endfunction

    function automatic t_result window_advance(input logic op, input t_seq seq,
                                               input logic [PLEN_W-1:0] plen);
        t_result r;
        t_seq    offset;
        r.ack_valid = 1'b0;
        r.store_payload = 1'b0;
        if (rx_state == ST_FINISHED || rx_state == ST_FAILED) begin
            r.ack_valid = 1'b0;
        end else if (op == OP_TIMEOUT) begin
            rx_state = (rx_state == ST_LINGER) ? ST_FINISHED : ST_FAILED;
        end else begin
            offset = seq - rx_base;
            if (32'(offset) < window_span(rx_window_cfg)) begin
                if (!rx_held[offset[IDX_W-1:0]]) begin
                    rx_held[offset[IDX_W-1:0]] = 1'b1;
                    r.store_payload = 1'b1;
                    if (plen < CHUNK_BYTES) begin
                        rx_last_seq = seq;
                        rx_last_known = 1'b1;
                    end
                end
                while (rx_held[0]) begin
                    rx_held = rx_held >> 1;
                    rx_base = rx_base + t_seq'(1);
                end
            end
            if (rx_last_known && t_seq'(rx_last_seq - rx_base) >= t_seq'(WINDOW_MAX)) begin
                rx_state = ST_LINGER;
            end else begin
                rx_state = ST_RECEIVING;
            end
            r.ack_valid = 1'b1;
        end
        r.ack_base = rx_base;
        r.sack_bits = {1'b0, rx_held[WINDOW_MAX-1:1]};
        r.status = rx_state;
        return r;
    endfunction

    // Source side: each word is offered after its own idle gap and held until taken.
    always @(negedge clk) begin
        t_seg_word w;
        if (!rst_n) begin
            seg_if.valid <= 1'b0;
            src_wait <= 0;
        end else if (!seg_if.valid || seg_acc) begin
            if (src_wait != 0) begin
                seg_if.valid <= 1'b0;
                src_wait <= src_wait - 1;
            end else if (seg_pending.size() != 0) begin
                w = seg_pending.pop_front();
                seg_if.valid <= 1'b1;
                seg_if.operation <= w.op;
                seg_if.seq_num <= w.seq;
                seg_if.payload_len <= w.plen;
                src_wait <= idle_draw(src_burst);
            end else begin
                seg_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        seg_acc <= seg_if.valid && seg_if.ready;
        if (rst_n && seg_if.valid && seg_if.ready) begin
            ack_expected.push_back(window_advance(seg_if.operation, seg_if.seq_num,
                                                  seg_if.payload_len));
            words_taken++;
        end
    end

    // Sink side: random stalls per word, plus one long hold-off on request.
    always @(negedge clk) begin
        int unsigned gap;
        if (!rst_n) begin
            ack_if.ready <= 1'b0;
            snk_wait <= 0;
        end else if (ack_hold_req && !hold_done) begin
            ack_if.ready <= 1'b0;
            hold_left <= 150;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            ack_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (ack_fire) begin
            gap = idle_draw(snk_burst);
            ack_if.ready <= (gap == 0);
            snk_wait <= (gap == 0) ? 0 : gap - 1;
        end else if (snk_wait != 0) begin
            ack_if.ready <= 1'b0;
            snk_wait <= snk_wait - 1;
        end else begin
            ack_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_result got;
        t_result want;
        ack_fire <= ack_if.valid && ack_if.ready;
        if (rst_n && ack_if.valid && ack_if.ready) begin
            got.ack_valid = ack_if.ack_valid;
            got.ack_base = ack_if.ack_base;
            got.sack_bits = ack_if.sack_bits;
            got.store_payload = ack_if.store_payload;
            got.status = t_status'(ack_if.status);
            if (ack_expected.size() == 0) begin
                ack_errors++;
                if (ack_errors <= 10) begin
                    $display("unexpected ack word: base=%0d status=%0d", got.ack_base,
                             got.status);
                end
            end else begin
                want = ack_expected.pop_front();
                if (got.ack_valid !== want.ack_valid || got.ack_base !== want.ack_base ||
                    got.sack_bits !== want.sack_bits ||
                    got.store_payload !== want.store_payload ||
                    got.status !== want.status) begin
                    ack_errors++;
                    if (ack_errors <= 10) begin
                        $display("ack mismatch: exp %0b %0d %h %0b %0d got %0b %0d %h %0b %0d",
                                 want.ack_valid, want.ack_base, want.sack_bits,
                                 want.store_payload, want.status, got.ack_valid,
                                 got.ack_base, got.sack_bits, got.store_payload, got.status);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("selective_repeat_receiver_window_top verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic op, input t_seq seq, input logic [PLEN_W-1:0] plen,
                             input logic from_base);
        t_seg_word w;
        do @(posedge clk); while (seg_pending.size() >= 2);
        w.op = op;
        w.seq = from_base ? t_seq'(rx_base + seq) : seq;
        w.plen = plen;
        seg_pending.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || ack_expected.size() != 0) @(negedge clk);
    endtask

    task automatic write_window(input logic [WIN_CFG_W-1:0] value);
        wait_idle();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        rx_window_cfg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_segment();
        int unsigned       span;
        int unsigned       pick;
        t_seq              offset;
        logic [PLEN_W-1:0] plen;
        span = window_span(rx_window_cfg);
        pick = $urandom_range(99, 0);
        if (pick < 78) begin
            offset = t_seq'($urandom_range($urandom_range(span - 1, 0), 0));
        end else if (pick < 88) begin
            offset = t_seq'(span + $urandom_range(6, 0));
        end else if (pick < 94) begin
            offset = -t_seq'($urandom_range(40, 1));
        end else begin
            offset = t_seq'($urandom);
        end
        pick = $urandom_range(99, 0);
        if (pick < 4) begin
            plen = PLEN_W'($urandom_range(999, 0));
        end else if (pick < 20) begin
            plen = PLEN_W'($urandom_range(1023, 1000));
        end else begin
            plen = CHUNK_BYTES;
        end
        send_word(OP_SEGMENT, offset, plen, 1'b1);
    endtask

    initial begin
        int unsigned          count;
        logic [WIN_CFG_W-1:0] win;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Duplicates, window edges, far and stale segments, and replaced final segments.
        send_word(OP_SEGMENT, 16'd0, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'd0, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'd2, 10'd1023, 1'b0);
        send_word(OP_SEGMENT, 16'd2, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'd32, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'd33, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'hFFFF, 10'd0, 1'b0);
        send_word(OP_SEGMENT, 16'hAAAA, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'd1, 10'd999, 1'b0);
        send_word(OP_SEGMENT, 16'd3, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'd10, 10'd0, 1'b0);
        for (int s = 4; s < 10; s++) begin
            send_word(OP_SEGMENT, t_seq'(s), CHUNK_BYTES, 1'b0);
        end
        send_word(OP_SEGMENT, 16'd12, CHUNK_BYTES, 1'b0);
        send_word(OP_SEGMENT, 16'd40, CHUNK_BYTES, 1'b0);

        for (int p = 0; p < 13; p++) begin
            case (p)
                0: win = 6'd1;
                1: win = 6'd0;
                2: win = 6'd63;
                3: win = 6'd32;
                4: win = 6'd33;
                default: win = (p % 2 == 1) ? WIN_CFG_W'($urandom_range(31, 2))
                                            : WIN_CFG_W'($urandom_range(63, 0));
            endcase
            write_window(win);
            src_burst = (p == 3) || (p % 4 == 1);
            snk_burst = (p != 3) && (p % 3 == 2);
            count = (p < 3) ? 20 : 88;
            for (int i = 0; i < count; i++) begin
                if (p == 3 && i == 10) begin
                    ack_hold_req = 1'b1;
                end
                random_segment();
            end
        end

        // Close the transfer: usually complete it first so the timeout finishes it.
        wait_idle();
        src_burst = 1'b0;
        snk_burst = 1'b0;
        if ($urandom_range(3, 0) != 0) begin
            send_word(OP_SEGMENT, '0, PLEN_W'($urandom_range(999, 0)), 1'b1);
        end
        send_word(OP_TIMEOUT, t_seq'($urandom), PLEN_W'($urandom), 1'b0);
        for (int i = 0; i < 6; i++) begin
            send_word(1'($urandom), t_seq'($urandom_range(40, 0)), PLEN_W'($urandom), 1'b1);
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (ack_errors == 0 && ack_expected.size() == 0) begin
            $display("selective_repeat_receiver_window_top verification clean");
        end else begin
            $display("selective_repeat_receiver_window_top verification failed");
        end
        $finish;
    end

endmodule
